// File: design/csup_pkg.sv
package csup_pkg;

  // bank size and field widths
  localparam int NumUnitsDefault = 4;
  localparam int DelayW          = 16;
  localparam int IdxW            = 3;
  localparam int SenseW          = 4;
  localparam logic [DelayW-1:0] DelayReset = DelayW'(100);

  // request codes
  typedef enum logic [1:0] {
    REQ_SET      = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_OPEN_ALL = 2'd3
  } csup_req_e;

  // per-request control handed to every contactor slice
  typedef struct packed {
    logic tick;
    logic open_all;
    logic set_norm;
    logic set_emerg;
    logic close;
  } csup_ctrl_t;

  // per-slice status seen by the top level
  typedef struct packed {
    logic commanded;
    logic faulted;
    logic running;
    logic expire_fault;
  } csup_stat_t;

endpackage

// File: design/contactor_supervisor.sv
// Contactor bank supervisor.
// Requests enter on start/busy: a request is taken at a rising edge with start
// high and busy low. busy is always low, so a request may be issued every cycle.
// Each request yields exactly one result, shown for one cycle with done_o high.
// It passes through the input register and then the result register, which is
// loaded with the state update. Sustained rate is one request per cycle; the
// per-contactor slices update all countdowns in parallel.
// drive_bits_o, latched_o and fault_bit_o show the state after the request
// whose result is on the ports; status_o, sensed_closed_o and
// contactor_faulted_o belong to that request alone.
// The receiver cannot stall: results must be taken in the cycle they appear.
// The sense delay register (cfg_we_i/cfg_wdata_i) is to be written while idle;
// the block does not enforce this. Reset (rst_ni low) opens all contactors, stops
// all countdowns, clears the faults and the emergency latch, and sets the sense
// delay to 100 ticks. The block takes requests from the first cycle after reset.
module contactor_supervisor #(
  parameter int NUM_UNITS = csup_pkg::NumUnitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic [csup_pkg::IdxW-1:0]    contactor_index_i,
  input  logic                         close_request_i,
  input  logic                         emergency_i,
  input  logic [csup_pkg::SenseW-1:0]  sense_bits_i,
  input  logic                         cfg_we_i,
  input  logic [csup_pkg::DelayW-1:0]  cfg_wdata_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic                         sensed_closed_o,
  output logic                         contactor_faulted_o,
  output logic [csup_pkg::SenseW-1:0]  drive_bits_o,
  output logic                         latched_o,
  output logic                         fault_bit_o
);
  import csup_pkg::*;

  localparam logic [IdxW:0] NumUnitsW = (IdxW+1)'(NUM_UNITS);

  // input register
  logic              valid_q;
  logic [1:0]        req_q;
  logic [IdxW-1:0]   idx_q;
  logic              close_q;
  logic              emerg_q;
  logic [SenseW-1:0] sense_q;

  // configuration and global state
  logic [DelayW-1:0] delay_q;
  logic              latch_q, latch_d;
  logic              gfault_q, gfault_d;

  // result register
  logic done_q, status_q, sensed_q, faulted_q;
  logic status_d, sensed_d, faulted_d;

  csup_req_e            req;
  csup_ctrl_t           ctrl;
  csup_stat_t           stat [NUM_UNITS];
  logic [NUM_UNITS-1:0] sel_vec, cmd_vec, fault_vec, idle_vec, expire_vec;
  logic                 idx_ok, set_ok, q_sensed, q_cmd, q_fault, q_idle;

  assign busy = 1'b0;

  // capture a request on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q   <= req_type_i;
      idx_q   <= contactor_index_i;
      close_q <= close_request_i;
      emerg_q <= emergency_i;
      sense_q <= sense_bits_i;
    end
  end

  // sense delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  // request decode
  assign req    = csup_req_e'(req_q);
  assign idx_ok = {1'b0, idx_q} < NumUnitsW;
  assign set_ok = valid_q && (req == REQ_SET) && idx_ok && (!latch_q || emerg_q);

  assign ctrl.tick      = valid_q && (req == REQ_TICK);
  assign ctrl.open_all  = valid_q && (req == REQ_OPEN_ALL);
  assign ctrl.set_norm  = set_ok && !emerg_q;
  assign ctrl.set_emerg = set_ok && emerg_q;
  assign ctrl.close     = close_q;

  // contactor slices
  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
    logic sensed;
    if (i < SenseW) begin : g_sensed
      assign sensed = sense_q[i];
    end else begin : g_open
      assign sensed = 1'b0;
    end

    assign sel_vec[i] = (idx_q == IdxW'(i));

    csup_unit u_unit (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sel_i    (sel_vec[i]),
      .sensed_i (sensed),
      .delay_i  (delay_q),
      .stat_o   (stat[i])
    );

    assign cmd_vec[i]    = stat[i].commanded;
    assign fault_vec[i]  = stat[i].faulted;
    assign idle_vec[i]   = !stat[i].running;
    assign expire_vec[i] = stat[i].expire_fault;
  end

  // drive levels for the first four contactors
  for (genvar b = 0; b < SenseW; b++) begin : g_drive
    if (b < NUM_UNITS) begin : g_on
      assign drive_bits_o[b] = cmd_vec[b];
    end else begin : g_off
      assign drive_bits_o[b] = 1'b0;
    end
  end

  // queried contactor
  assign q_sensed = ({1'b0, idx_q} < (IdxW+1)'(SenseW)) ? sense_q[idx_q[1:0]] : 1'b0;
  assign q_cmd    = |(cmd_vec & sel_vec);
  assign q_fault  = |(fault_vec & sel_vec);
  assign q_idle   = |(idle_vec & sel_vec);

  // latch and global fault
  assign latch_d  = latch_q | ctrl.set_emerg | ctrl.open_all;
  assign gfault_d = gfault_q | (|expire_vec);

  // per-request answer
  always_comb begin
    status_d  = 1'b0;
    sensed_d  = 1'b0;
    faulted_d = 1'b0;
    unique case (req)
      REQ_SET: begin
        status_d = !set_ok;
      end
      REQ_QUERY: begin
        if (!idx_ok) begin
          status_d = 1'b1;
        end else begin
          sensed_d  = q_sensed;
          faulted_d = q_fault;
          status_d  = q_idle && (q_sensed != q_cmd);
        end
      end
      REQ_TICK, REQ_OPEN_ALL: begin
        status_d = 1'b0;
      end
      default: begin
        status_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= 1'b0;
      gfault_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      latch_q  <= latch_d;
      gfault_q <= gfault_d;
      done_q   <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      status_q  <= status_d;
      sensed_q  <= sensed_d;
      faulted_q <= faulted_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign sensed_closed_o     = sensed_q;
  assign contactor_faulted_o = faulted_q;
  assign latched_o           = latch_q;
  assign fault_bit_o         = gfault_q;

`ifndef SYNTHESIS
  // emergency latch is one-way
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_o |=> latched_o) else $error("emergency latch cleared");

  // global fault is sticky
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_bit_o |=> fault_bit_o) else $error("global fault cleared");

  // any contactor fault shows in the global fault
  a_fault_global: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|fault_vec) |-> fault_bit_o) else $error("contactor fault without global fault");

  // a result follows a transfer through the input and result registers
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o) else $error("result missing after transfer");

  // a normal set never lands while latched
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> !ctrl.set_norm) else $error("normal set accepted while latched");
`endif

endmodule

// File: design/csup_unit.sv
module csup_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csup_pkg::csup_ctrl_t       ctrl_i,
  input  logic                       sel_i,
  input  logic                       sensed_i,
  input  logic [csup_pkg::DelayW-1:0] delay_i,
  output csup_pkg::csup_stat_t       stat_o
);
  import csup_pkg::*;

  logic              cmd_q, cmd_d;
  logic              fault_q, fault_d;
  logic [DelayW-1:0] cnt_q, cnt_d;
  logic              expire_fault;

  // countdown reaching zero on this tick with a sense mismatch
  assign expire_fault = ctrl_i.tick && (cnt_q == DelayW'(1)) && (sensed_i != cmd_q);

  // commanded state
  always_comb begin
    cmd_d = cmd_q;
    if (ctrl_i.open_all) begin
      cmd_d = 1'b0;
    end else if (sel_i && (ctrl_i.set_norm || ctrl_i.set_emerg)) begin
      cmd_d = ctrl_i.close;
    end
  end

  // verify countdown, a zero load is taken as one
  always_comb begin
    cnt_d = cnt_q;
    if (sel_i && ctrl_i.set_norm) begin
      cnt_d = (delay_i == '0) ? DelayW'(1) : delay_i;
    end else if (ctrl_i.tick && (cnt_q != '0)) begin
      cnt_d = cnt_q - DelayW'(1);
    end
  end

  assign fault_d = fault_q | expire_fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= 1'b0;
      fault_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cmd_q   <= cmd_d;
      fault_q <= fault_d;
      cnt_q   <= cnt_d;
    end
  end

  assign stat_o.commanded    = cmd_q;
  assign stat_o.faulted      = fault_q;
  assign stat_o.running      = (cnt_q != '0);
  assign stat_o.expire_fault = expire_fault;

endmodule

// File: sim/contactor_supervisor_tb.sv
module contactor_supervisor_tb;
  import csup_pkg::*;

  localparam int NumUnits   = NumUnitsDefault;
  localparam int StallLimit = 1000;
  localparam int DrainWait  = 10;

  // one request as the sender sees it; track makes the sense bits follow
  // the commanded levels at drive time, with sense used as a flip mask
  typedef struct packed {
    csup_req_e         req;
    logic [IdxW-1:0]   idx;
    logic              close;
    logic              emerg;
    logic [SenseW-1:0] sense;
    logic              track;
  } sup_request_t;

  // one reply of the block
  typedef struct packed {
    logic              status;
    logic              sensed;
    logic              faulted;
    logic [SenseW-1:0] drive;
    logic              latched;
    logic              fault;
  } sup_reply_t;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              start               = 1'b0;
  logic              busy;
  csup_req_e         req_type_i          = REQ_SET;
  logic [IdxW-1:0]   contactor_index_i   = '0;
  logic              close_request_i     = 1'b0;
  logic              emergency_i         = 1'b0;
  logic [SenseW-1:0] sense_bits_i        = '0;
  logic              cfg_we_i            = 1'b0;
  logic [DelayW-1:0] cfg_wdata_i         = '0;
  logic              done_o;
  logic              status_o;
  logic              sensed_closed_o;
  logic              contactor_faulted_o;
  logic [SenseW-1:0] drive_bits_o;
  logic              latched_o;
  logic              fault_bit_o;

  // mirror of the supervisor state
  logic [NumUnits-1:0] cmd_closed  = '0;
  logic [DelayW-1:0]   verify_left [NumUnits];
  logic [NumUnits-1:0] unit_fault  = '0;
  logic                latch_set   = 1'b0;
  logic                fault_seen  = 1'b0;
  logic [DelayW-1:0]   delay_ticks = DelayReset;

  sup_request_t requests_todo [$];
  sup_reply_t   replies_due [$];
  sup_request_t on_port;
  sup_request_t next_req;
  sup_reply_t   reply_now;
  sup_reply_t   reply_want;
  int           gap_left     = 0;
  bit           idle_en      = 1'b1;
  int           errors       = 0;
  int           stall_cycles = 0;

  contactor_supervisor #(
    .NUM_UNITS(NumUnits)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .contactor_index_i  (contactor_index_i),
    .close_request_i    (close_request_i),
    .emergency_i        (emergency_i),
    .sense_bits_i       (sense_bits_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .sensed_closed_o    (sensed_closed_o),
    .contactor_faulted_o(contactor_faulted_o),
    .drive_bits_o       (drive_bits_o),
    .latched_o          (latched_o),
    .fault_bit_o        (fault_bit_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NumUnits; i++) verify_left[i] = '0;
  end

  // commanded levels as they show on the drive outputs
  function automatic logic [SenseW-1:0] cmd_levels();
    logic [SenseW-1:0] lv;
    lv = '0;
    for (int i = 0; i < NumUnits && i < SenseW; i++) lv[i] = cmd_closed[i];
    return lv;
  endfunction

  // state update and reply for one request
  task automatic apply_request(input sup_request_t rq, output sup_reply_t rp);
    logic sensed_i;
    rp = '0;
    case (rq.req)
      REQ_SET: begin
        if (rq.idx >= NumUnits || (latch_set && !rq.emerg)) begin
          rp.status = 1'b1;
        end else begin
          cmd_closed[rq.idx] = rq.close;
          if (rq.emerg) begin
            latch_set = 1'b1;
          end else begin
            verify_left[rq.idx] = (delay_ticks == '0) ? DelayW'(1) : delay_ticks;
          end
        end
      end
      REQ_QUERY: begin
        if (rq.idx >= NumUnits) begin
          rp.status = 1'b1;
        end else begin
          rp.sensed  = (rq.idx < SenseW) ? rq.sense[rq.idx] : 1'b0;
          rp.faulted = unit_fault[rq.idx];
          if (verify_left[rq.idx] == '0 && rp.sensed != cmd_closed[rq.idx]) rp.status = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < NumUnits; i++) begin
          if (verify_left[i] != '0) begin
            verify_left[i] = verify_left[i] - 1'b1;
            sensed_i = (i < SenseW) ? rq.sense[i] : 1'b0;
            if (verify_left[i] == '0 && sensed_i != cmd_closed[i]) begin
              unit_fault[i] = 1'b1;
              fault_seen    = 1'b1;
            end
          end
        end
      end
      default: begin
        latch_set  = 1'b1;
        cmd_closed = '0;
      end
    endcase
    rp.drive   = cmd_levels();
    rp.latched = latch_set;
    rp.fault   = fault_seen;
  endtask

  // random request; emergencies only once the latch may be set
  function automatic sup_request_t random_request(input bit emerg_ok);
    sup_request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rq.req = REQ_SET;
    end else if (pick < 65) begin
      rq.req = REQ_QUERY;
    end else if (emerg_ok && pick >= 93) begin
      rq.req = REQ_OPEN_ALL;
    end else begin
      rq.req = REQ_TICK;
    end
    if ($urandom_range(0, 9) < 8) begin
      rq.idx = IdxW'($urandom_range(0, NumUnits - 1));
    end else begin
      rq.idx = IdxW'($urandom_range(0, 7));
    end
    rq.close = 1'($urandom_range(0, 1));
    rq.emerg = 1'($urandom_range(0, 1));
    if (rq.req == REQ_SET) begin
      rq.emerg = emerg_ok ? ($urandom_range(0, 5) == 0) : 1'b0;
    end
    rq.track = ($urandom_range(0, 3) != 0);
    if (rq.track) begin
      rq.sense = ($urandom_range(0, 7) == 0) ? SenseW'(1 << $urandom_range(0, SenseW - 1)) : '0;
    end else begin
      rq.sense = SenseW'($urandom_range(0, 15));
    end
    return rq;
  endfunction

  task automatic add_request(input csup_req_e r, input int unsigned idx, input bit cl,
                             input bit em, input int unsigned sn);
    sup_request_t rq;
    rq.req   = r;
    rq.idx   = IdxW'(idx);
    rq.close = cl;
    rq.emerg = em;
    rq.sense = SenseW'(sn);
    rq.track = 1'b0;
    requests_todo.push_back(rq);
  endtask

  task automatic fill_random(input int count, input bit emerg_ok);
    for (int k = 0; k < count; k++) requests_todo.push_back(random_request(emerg_ok));
  endtask

  // wait until nothing is queued, on the ports or outstanding
  task automatic drain();
    do @(negedge clk_i);
    while (requests_todo.size() != 0 || start || replies_due.size() != 0);
  endtask

  // sense delay write, only with the block idle
  task automatic set_delay(input logic [DelayW-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    delay_ticks = value;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start             <= 1'b0;
      req_type_i        <= REQ_SET;
      contactor_index_i <= '0;
      close_request_i   <= 1'b0;
      emergency_i       <= 1'b0;
      sense_bits_i      <= '0;
      gap_left          <= 0;
    end else begin
      // request transfer at this edge
      if (start && !busy) begin
        apply_request(on_port, reply_now);
        replies_due.push_back(reply_now);
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (requests_todo.size() != 0) begin
          next_req = requests_todo.pop_front();
          if (next_req.track) next_req.sense = cmd_levels() ^ next_req.sense;
          on_port            = next_req;
          req_type_i        <= next_req.req;
          contactor_index_i <= next_req.idx;
          close_request_i   <= next_req.close;
          emergency_i       <= next_req.emerg;
          sense_bits_i      <= next_req.sense;
          start             <= 1'b1;
          if (idle_en && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 3);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // reply monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none outstanding, expected none actual status %0h drive %0h",
                 $time, status_o, drive_bits_o);
        errors++;
      end else begin
        reply_want = replies_due.pop_front();
        check_field("status", 4'(reply_want.status), 4'(status_o));
        check_field("sensed_closed", 4'(reply_want.sensed), 4'(sensed_closed_o));
        check_field("contactor_faulted", 4'(reply_want.faulted), 4'(contactor_faulted_o));
        check_field("drive_bits", 4'(reply_want.drive), 4'(drive_bits_o));
        check_field("latched", 4'(reply_want.latched), 4'(latched_o));
        check_field("fault_bit", 4'(reply_want.fault), 4'(fault_bit_o));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // queries and sets on valid and invalid units at the reset delay
    add_request(REQ_QUERY, 0, 1'b0, 1'b0, 4'h0);
    add_request(REQ_QUERY, 7, 1'b1, 1'b1, 4'hF);
    add_request(REQ_QUERY, NumUnits, 1'b0, 1'b0, 4'hF);
    add_request(REQ_QUERY, 3, 1'b0, 1'b0, 4'hF);
    add_request(REQ_SET, 5, 1'b1, 1'b0, 4'h0);
    add_request(REQ_SET, 7, 1'b1, 1'b0, 4'h0);
    add_request(REQ_SET, 0, 1'b1, 1'b0, 4'h0);
    add_request(REQ_QUERY, 0, 1'b0, 1'b0, 4'h0);
    // restart of a running countdown
    add_request(REQ_SET, 0, 1'b1, 1'b0, 4'h0);
    add_request(REQ_SET, 3, 1'b1, 1'b0, 4'h0);
    add_request(REQ_TICK, 0, 1'b0, 1'b0, 4'hF);

    // zero delay behaves as one tick
    set_delay('0);
    add_request(REQ_SET, 1, 1'b1, 1'b0, 4'h0);
    add_request(REQ_TICK, 0, 1'b0, 1'b1, 4'h0);
    add_request(REQ_QUERY, 1, 1'b0, 1'b0, 4'h0);
    add_request(REQ_SET, 2, 1'b1, 1'b0, 4'h0);
    add_request(REQ_TICK, 0, 1'b0, 1'b0, 4'h4);
    add_request(REQ_QUERY, 2, 1'b0, 1'b0, 4'h0);

    // random phases with the latch clear
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_delay(DelayW'(1));
        1: set_delay(DelayW'(3));
        2: set_delay('1);
        3: set_delay('0);
        4: set_delay(DelayW'(6));
        default: set_delay(DelayW'(2));
      endcase
      idle_en = (p != 4);
      fill_random(200, 1'b0);
    end

    // emergency part, no idling from here on
    set_delay(DelayW'(4));
    idle_en = 1'b0;
    add_request(REQ_SET, 3, 1'b1, 1'b0, 4'h0);
    add_request(REQ_SET, 0, 1'b1, 1'b0, 4'h0);
    // emergency write over a running countdown sets the latch
    add_request(REQ_SET, 0, 1'b0, 1'b1, 4'h0);
    add_request(REQ_SET, 1, 1'b1, 1'b0, 4'h0);
    add_request(REQ_SET, 2, 1'b1, 1'b1, 4'h0);
    // open-all leaves countdowns running
    add_request(REQ_OPEN_ALL, 0, 1'b0, 1'b0, 4'h0);
    repeat (4) add_request(REQ_TICK, 0, 1'b0, 1'b0, 4'h8);
    add_request(REQ_QUERY, 3, 1'b0, 1'b0, 4'h8);
    fill_random(250, 1'b1);

    drain();
    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
